@@ rtl/core/crc16fd_pkg.sv @@
// Shared constants, result word type and CRC-16-CCITT byte update for the
// sync-header frame deframer. No dependencies.
package crc16fd_pkg;

    localparam int MAX_PAYLOAD_BYTES = 64;
    localparam int HDR_BYTES         = 7;
    localparam int TRAILER_BYTES     = 2;
    localparam int MIN_FRAME         = HDR_BYTES + TRAILER_BYTES;
    localparam int COUNT_W           = 7;
    localparam int INDEX_W           = 8;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    typedef enum logic [0:0] {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_CRC_ERR   = 2'd2
    } status_t;

    typedef struct packed {
        logic               is_summary;
        logic [7:0]         payload_byte;
        status_t            status;
        logic [7:0]         src_node;
        logic [7:0]         dst_node;
        logic [7:0]         msg_type;
        logic [15:0]        msg_ident;
        logic [COUNT_W-1:0] payload_count;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ rtl/core/crc16_frame_deframer.sv @@
// Sync-header frame deframer with CRC-16-CCITT trailer check.
// Depends on crc16fd_pkg.
//
// Takes a byte per cycle when ready (sync0 sync1 src dst type id_lo id_hi
// payload... crc_lo crc_hi). Each byte is handled in the cycle it is
// accepted: sync compare, header capture and one unrolled CRC byte update
// update the frame registers, and the results it causes (at most a payload
// word and the frame summary) go into a four-entry output queue. Input
// ready is high while the queue has room for two words, so with the output
// side taking a word every cycle a byte is accepted every cycle; a frame's
// last byte adds a second word, which can hold input ready low. Payload
// words are tentative and leave two bytes late, so the trailer never
// appears; the summary status decides whether they are good.
module crc16_frame_deframer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              rx_byte,
    input  logic                    frame_end,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    is_summary,
    output logic [7:0]              payload_byte,
    output logic [1:0]              status,
    output logic [7:0]              src_node,
    output logic [7:0]              dst_node,
    output logic [7:0]              msg_type,
    output logic [15:0]             msg_ident,
    output logic [6:0]              payload_count,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [7:0]              cfg_data
);
    import crc16fd_pkg::*;

    logic [7:0]         sync_first_reg;
    logic [7:0]         sync_second_reg;

    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         delay0_reg, delay0_next;
    logic [7:0]         delay1_reg, delay1_next;
    logic [7:0]         hdr_src_reg, hdr_src_next;
    logic [7:0]         hdr_dst_reg, hdr_dst_next;
    logic [7:0]         hdr_type_reg, hdr_type_next;
    logic [15:0]        hdr_ident_reg, hdr_ident_next;
    logic               sync_bad_reg, sync_bad_next;

    result_t                fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]    count_reg;

    logic               accept;
    logic               pop;
    logic               pay_valid;
    result_t            pay_res;
    result_t            sum_res;
    result_t            res_a;
    result_t            res_b;
    logic [1:0]         push_cnt;
    logic [15:0]        crc_upd;
    logic [15:0]        trailer_word;
    logic [INDEX_W-1:0] pay_len;
    logic               too_long;
    logic               hdr_short;
    status_t            sum_status;
    logic [COUNT_W-1:0] sum_count;
    logic               sync_bad_upd;
    logic [7:0]         src_upd, dst_upd, type_upd;
    logic [15:0]        ident_upd;
    result_t            head;

    assign in_ready = count_reg <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2);
    assign accept   = in_valid && in_ready;
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-byte header capture, CRC update and payload/summary word build
    always_comb
    begin
        sync_bad_upd = sync_bad_reg;
        src_upd      = hdr_src_reg;
        dst_upd      = hdr_dst_reg;
        type_upd     = hdr_type_reg;
        ident_upd    = hdr_ident_reg;
        case (byte_index_reg)
            INDEX_W'(0): sync_bad_upd = sync_bad_reg || (rx_byte != sync_first_reg);
            INDEX_W'(1): sync_bad_upd = sync_bad_reg || (rx_byte != sync_second_reg);
            INDEX_W'(2): src_upd      = rx_byte;
            INDEX_W'(3): dst_upd      = rx_byte;
            INDEX_W'(4): type_upd     = rx_byte;
            INDEX_W'(5): ident_upd    = {hdr_ident_reg[15:8], rx_byte};
            INDEX_W'(6): ident_upd    = {rx_byte, hdr_ident_reg[7:0]};
            default: ;
        endcase

        crc_upd = (byte_index_reg >= INDEX_W'(4)) ? crc16_byte(crc_reg, delay0_reg) : crc_reg;

        pay_valid = byte_index_reg >= INDEX_W'(MIN_FRAME);
        pay_res              = '0;
        pay_res.payload_byte = delay0_reg;

        trailer_word = {rx_byte, delay1_reg};
        hdr_short = byte_index_reg < INDEX_W'(MIN_FRAME - 1);
        pay_len   = byte_index_reg - INDEX_W'(MIN_FRAME - 1);
        too_long  = (byte_index_reg == '1) || (pay_len > INDEX_W'(MAX_PAYLOAD_BYTES));
        sum_count = '0;
        if (hdr_short || sync_bad_upd)
            sum_status = STATUS_MALFORMED;
        else
        begin
            if (too_long)
            begin
                sum_count  = COUNT_W'(MAX_PAYLOAD_BYTES);
                sum_status = STATUS_MALFORMED;
            end
            else
            begin
                sum_count  = pay_len[COUNT_W-1:0];
                sum_status = STATUS_OK;
            end
            if (trailer_word != crc_upd)
                sum_status = STATUS_CRC_ERR;
        end

        sum_res               = '0;
        sum_res.is_summary    = 1'b1;
        sum_res.status        = sum_status;
        sum_res.src_node      = src_upd;
        sum_res.dst_node      = dst_upd;
        sum_res.msg_type      = type_upd;
        sum_res.msg_ident     = ident_upd;
        sum_res.payload_count = sum_count;

        res_a    = pay_valid ? pay_res : sum_res;
        res_b    = sum_res;
        push_cnt = accept ? ({1'b0, pay_valid} + {1'b0, frame_end}) : 2'd0;

        if (frame_end)
        begin
            byte_index_next = '0;
            crc_next        = CRC_INIT;
            delay0_next     = '0;
            delay1_next     = '0;
            hdr_src_next    = '0;
            hdr_dst_next    = '0;
            hdr_type_next   = '0;
            hdr_ident_next  = '0;
            sync_bad_next   = 1'b0;
        end
        else
        begin
            byte_index_next = (byte_index_reg == '1) ? byte_index_reg
                                                     : byte_index_reg + INDEX_W'(1);
            crc_next        = crc_upd;
            delay0_next     = delay1_reg;
            delay1_next     = rx_byte;
            hdr_src_next    = src_upd;
            hdr_dst_next    = dst_upd;
            hdr_type_next   = type_upd;
            hdr_ident_next  = ident_upd;
            sync_bad_next   = sync_bad_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            crc_reg        <= CRC_INIT;
            delay0_reg     <= '0;
            delay1_reg     <= '0;
            hdr_src_reg    <= '0;
            hdr_dst_reg    <= '0;
            hdr_type_reg   <= '0;
            hdr_ident_reg  <= '0;
            sync_bad_reg   <= 1'b0;
        end
        else if (accept)
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            delay0_reg     <= delay0_next;
            delay1_reg     <= delay1_next;
            hdr_src_reg    <= hdr_src_next;
            hdr_dst_reg    <= hdr_dst_next;
            hdr_type_reg   <= hdr_type_next;
            hdr_ident_reg  <= hdr_ident_next;
            sync_bad_reg   <= sync_bad_next;
        end
    end

    // output queue
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_mem_reg[wr_ptr_reg] <= res_a;
        if (push_cnt == 2'd2)
            fifo_mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push_cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_reg + (FIFO_PTR_W+1)'(push_cnt) - (FIFO_PTR_W+1)'(pop);
        end
    end

    assign head          = fifo_mem_reg[rd_ptr_reg];
    assign is_summary    = head.is_summary;
    assign payload_byte  = head.payload_byte;
    assign status        = head.status;
    assign src_node      = head.src_node;
    assign dst_node      = head.dst_node;
    assign msg_type      = head.msg_type;
    assign msg_ident     = head.msg_ident;
    assign payload_count = head.payload_count;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> byte_index_reg == '0 && crc_reg == CRC_INIT && !sync_bad_reg)
        else $error("frame state not cleared after last byte");

    a_crc_idle_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= INDEX_W'(4) |-> crc_reg == CRC_INIT)
        else $error("CRC advanced inside header");

    a_payload_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_summary |-> status == STATUS_OK && payload_count == '0)
        else $error("payload word carries summary fields");

    a_summary_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_summary |-> status != 2'd3 && payload_byte == '0)
        else $error("bad summary word");

endmodule
